// File: rtl/core/ialu_pkg.sv
// Shared constants and types for the integer ALU core.
`default_nettype none
package ialu_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int OPCODE_WIDTH   = 3;
   localparam int DIGIT_BITS     = 8;

   localparam logic [OPCODE_WIDTH-1:0] OPC_ADD = 3'd0;
   localparam logic [OPCODE_WIDTH-1:0] OPC_SUB = 3'd1;
   localparam logic [OPCODE_WIDTH-1:0] OPC_MUL = 3'd2;
   localparam logic [OPCODE_WIDTH-1:0] OPC_DIV = 3'd3;
   localparam logic [OPCODE_WIDTH-1:0] OPC_REM = 3'd4;
   localparam logic [OPCODE_WIDTH-1:0] OPC_POW = 3'd5;

   typedef struct packed {
      logic start;
      logic is_div;
   } unit_cmd_type;

   typedef struct packed {
      logic done;
   } unit_sts_type;

endpackage
`default_nettype wire

// File: rtl/core/ialu_unit.sv
// Shared iterative unit: digit-serial multiply (low half) and radix-2 restoring divide.
`default_nettype none
module ialu_unit #(
   parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ialu_pkg::unit_cmd_type     cmd,
   input  logic [DATA_WIDTH-1:0]      opa,
   input  logic [DATA_WIDTH-1:0]      opb,
   output ialu_pkg::unit_sts_type     sts,
   output logic [DATA_WIDTH-1:0]      acc_out,
   output logic [DATA_WIDTH-1:0]      quo_out
);
   import ialu_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  y_ff, y_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          div_ff, div_in;
   logic          done_ff, done_in;

   logic [W-1:0]            pp;
   logic [W:0]              trial;
   logic                    qbit;

   // one digit of the multiplier per step
   assign pp = x_ff * W'(y_ff[DIGIT_BITS-1:0]);
   // trial subtract for division
   assign trial = {acc_ff, y_ff[W-1]} - {1'b0, x_ff};
   assign qbit  = ~trial[W];

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      div_in  = div_ff;
      done_in = 1'b0;
      if (!busy_ff) begin
         if (cmd.start) begin
            busy_in = 1'b1;
            div_in  = cmd.is_div;
            acc_in  = '0;
            cnt_in  = CW'(W);
            if (cmd.is_div) begin
               x_in = opb;
               y_in = opa;
            end else begin
               x_in = opa;
               y_in = opb;
            end
         end
      end else if (div_ff) begin
         if (qbit) begin
            acc_in = trial[W-1:0];
         end else begin
            acc_in = {acc_ff[W-2:0], y_ff[W-1]};
         end
         y_in   = {y_ff[W-2:0], qbit};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else begin
         acc_in = acc_ff + pp;
         x_in   = x_ff << DIGIT_BITS;
         y_in   = y_ff >> DIGIT_BITS;
         if ((y_ff >> DIGIT_BITS) == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         div_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         div_ff  <= div_in;
         cnt_ff  <= cnt_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   assign sts.done = done_ff;
   assign acc_out  = acc_ff;
   assign quo_out  = y_ff;

endmodule
`default_nettype wire

// File: rtl/core/integer_alu_mul_div_mod_pow_core.sv
// Top level: sequencer for add, subtract, multiply, divide, remainder and power.
// Power runs one multiply per squaring and per set exponent bit, up to 2*W-3 multiplies.
// One item at a time; req_stall is high while an item is in work.
// The result register frees the core, so a new item is taken while a result waits.
// Synchronous reset clears the sequencer, the shared unit and rsp_valid.
`default_nettype none
module integer_alu_mul_div_mod_pow_core #(
   parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ialu_pkg::OPCODE_WIDTH-1:0]    req_opcode,
   input  logic signed [DATA_WIDTH-1:0]         req_operand_a,
   input  logic signed [DATA_WIDTH-1:0]         req_operand_b,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [DATA_WIDTH-1:0]         rsp_result_value,
   output logic                                 rsp_divide_by_zero
);
   import ialu_pkg::*;

   localparam int W = DATA_WIDTH;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_WMUL   = 3'd1;
   localparam logic [2:0] ST_WDIV   = 3'd2;
   localparam logic [2:0] ST_PCHK   = 3'd3;
   localparam logic [2:0] ST_PML    = 3'd4;
   localparam logic [2:0] ST_PSQ    = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0]   state_ff, state_in;
   logic [W-1:0] res_ff, res_in;
   logic         dz_ff, dz_in;
   logic         neg_ff, neg_in;
   logic         rem_sel_ff, rem_sel_in;
   logic [W-1:0] pacc_ff, pacc_in;
   logic [W-1:0] sq_ff, sq_in;
   logic [W-1:0] e_ff, e_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [W-1:0] rsp_value_ff;
   logic         rsp_dz_ff;

   unit_cmd_type unit_cmd;
   unit_sts_type unit_sts;
   logic [W-1:0] unit_x, unit_y;
   logic [W-1:0] unit_acc, unit_quo;

   logic [W-1:0] a_u, b_u, mag_a, mag_b, div_val;
   logic         load_out;

   assign a_u   = req_operand_a;
   assign b_u   = req_operand_b;
   assign mag_a = a_u[W-1] ? (~a_u + W'(1)) : a_u;
   assign mag_b = b_u[W-1] ? (~b_u + W'(1)) : b_u;
   assign div_val = rem_sel_ff ? unit_acc : unit_quo;

   ialu_unit #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_unit (
      .clock   (clock),
      .reset   (reset),
      .cmd     (unit_cmd),
      .opa     (unit_x),
      .opb     (unit_y),
      .sts     (unit_sts),
      .acc_out (unit_acc),
      .quo_out (unit_quo)
   );

   assign load_out = (state_ff == ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in        = state_ff;
      res_in          = res_ff;
      dz_in           = dz_ff;
      neg_in          = neg_ff;
      rem_sel_in      = rem_sel_ff;
      pacc_in         = pacc_ff;
      sq_in           = sq_ff;
      e_in            = e_ff;
      unit_cmd.start  = 1'b0;
      unit_cmd.is_div = 1'b0;
      unit_x          = '0;
      unit_y          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dz_in    = 1'b0;
               res_in   = '0;
               state_in = ST_FINISH;
               case (req_opcode)
                  OPC_ADD: res_in = a_u + b_u;
                  OPC_SUB: res_in = a_u - b_u;
                  OPC_MUL: begin
                     unit_cmd.start = 1'b1;
                     unit_x         = a_u;
                     unit_y         = b_u;
                     state_in       = ST_WMUL;
                  end
                  OPC_DIV, OPC_REM: begin
                     if (b_u == '0) begin
                        dz_in = 1'b1;
                     end else begin
                        unit_cmd.start  = 1'b1;
                        unit_cmd.is_div = 1'b1;
                        unit_x          = mag_a;
                        unit_y          = mag_b;
                        rem_sel_in      = (req_opcode == OPC_REM);
                        neg_in          = (req_opcode == OPC_REM) ? a_u[W-1]
                                                                  : (a_u[W-1] ^ b_u[W-1]);
                        state_in        = ST_WDIV;
                     end
                  end
                  OPC_POW: begin
                     if (a_u == '1) begin
                        res_in = b_u[0] ? '1 : W'(1);
                     end else if (b_u == '0) begin
                        res_in = W'(1);
                     end else if (a_u == W'(1)) begin
                        res_in = W'(1);
                     end else if (a_u == '0 || b_u[W-1]) begin
                        res_in = '0;
                     end else begin
                        pacc_in  = W'(1);
                        sq_in    = a_u;
                        e_in     = b_u;
                        state_in = ST_PCHK;
                     end
                  end
                  default: res_in = '0;
               endcase
            end
         end
         ST_WMUL: begin
            if (unit_sts.done) begin
               res_in   = unit_acc;
               state_in = ST_FINISH;
            end
         end
         ST_WDIV: begin
            if (unit_sts.done) begin
               res_in   = neg_ff ? (~div_val + W'(1)) : div_val;
               state_in = ST_FINISH;
            end
         end
         ST_PCHK: begin
            unit_cmd.start = (e_ff != '0);
            if (e_ff == '0) begin
               res_in   = pacc_ff;
               state_in = ST_FINISH;
            end else if (e_ff[0]) begin
               unit_x   = pacc_ff;
               unit_y   = sq_ff;
               state_in = ST_PML;
            end else begin
               unit_x   = sq_ff;
               unit_y   = sq_ff;
               state_in = ST_PSQ;
            end
         end
         ST_PML: begin
            if (unit_sts.done) begin
               pacc_in = unit_acc;
               if (e_ff[W-1:1] == '0) begin
                  res_in   = unit_acc;
                  state_in = ST_FINISH;
               end else begin
                  unit_cmd.start = 1'b1;
                  unit_x         = sq_ff;
                  unit_y         = sq_ff;
                  state_in       = ST_PSQ;
               end
            end
         end
         ST_PSQ: begin
            if (unit_sts.done) begin
               sq_in    = unit_acc;
               e_in     = e_ff >> 1;
               state_in = ST_PCHK;
            end
         end
         ST_FINISH: begin
            if (load_out) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_ff     <= res_in;
      dz_ff      <= dz_in;
      neg_ff     <= neg_in;
      rem_sel_ff <= rem_sel_in;
      pacc_ff    <= pacc_in;
      sq_ff      <= sq_in;
      e_ff       <= e_in;
      if (load_out) begin
         rsp_value_ff <= res_ff;
         rsp_dz_ff    <= dz_ff;
      end
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_value   = $signed(rsp_value_ff);
   assign rsp_divide_by_zero = rsp_dz_ff;

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking bench for integer ALU core: directed and random items vs. local predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ialu_pkg::*;

   localparam int W = DATA_WIDTH_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 50;
   localparam int RANDOM_ITEMS = 400;

   localparam logic [OPCODE_WIDTH-1:0] OPC_RSVD_6 = 3'd6;
   localparam logic [OPCODE_WIDTH-1:0] OPC_RSVD_7 = 3'd7;

   typedef logic [W-1:0] word_type;

   localparam word_type W_MIN = {1'b1, {(W-1){1'b0}}};
   localparam word_type W_MAX = {1'b0, {(W-1){1'b1}}};
   localparam word_type W_ONE = 1;
   localparam word_type W_ALL = '1;

   typedef struct packed {
      logic [OPCODE_WIDTH-1:0] opcode;
      word_type                a;
      word_type                b;
   } alu_op_type;

   typedef struct packed {
      word_type value;
      logic     div_zero;
   } alu_res_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [OPCODE_WIDTH-1:0] req_opcode = '0;
   logic signed [W-1:0] req_operand_a = '0;
   logic signed [W-1:0] req_operand_b = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [W-1:0] rsp_result_value;
   logic rsp_divide_by_zero;

   alu_op_type  alu_requests[$];
   alu_res_type predicted_results[$];

   logic [OPCODE_WIDTH-1:0] opcode_list [8] = '{OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV,
                                                 OPC_REM, OPC_POW, OPC_RSVD_6, OPC_RSVD_7};
   word_type extreme_list [5] = '{W_MIN, W_MAX, '0, W_ONE, W_ALL};

   int unsigned calm_left [2] = '{0, 0};
   int unsigned req_gap = 0;
   int unsigned rsp_hold = 0;
   int unsigned op_transfers [8] = '{0, 0, 0, 0, 0, 0, 0, 0};
   int unsigned results_checked = 0;
   int unsigned item_total = 0;
   int unsigned zero_div_results = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   alu_op_type next_op;
   alu_res_type want;

   integer_alu_mul_div_mod_pow_core #(.DATA_WIDTH(W)) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_operand_a      (req_operand_a),
      .req_operand_b      (req_operand_b),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_value   (rsp_result_value),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic word_type raise_power(word_type base, word_type expo);
      word_type acc;
      word_type sq;
      word_type e;
      acc = W_ONE;
      sq = base;
      e = expo;
      if (base == W_ALL) return expo[0] ? W_ALL : W_ONE;
      if (expo == '0) return W_ONE;
      if (base == W_ONE) return W_ONE;
      if (base == '0) return '0;
      if (expo[W-1]) return '0;
      for (int i = 0; i < W; i++) begin
         if (e[0]) acc = acc * sq;
         sq = sq * sq;
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic alu_res_type alu_result_of(logic [OPCODE_WIDTH-1:0] op, word_type a,
                                                 word_type b);
      alu_res_type r;
      word_type ma;
      word_type mb;
      r.value = '0;
      r.div_zero = 1'b0;
      ma = a[W-1] ? -a : a;
      mb = b[W-1] ? -b : b;
      case (op)
         OPC_ADD: r.value = a + b;
         OPC_SUB: r.value = a - b;
         OPC_MUL: r.value = a * b;
         OPC_DIV: begin
            if (b == '0) begin
               r.div_zero = 1'b1;
            end else begin
               r.value = ma / mb;
               if (a[W-1] != b[W-1]) r.value = -r.value;
            end
         end
         OPC_REM: begin
            if (b == '0) begin
               r.div_zero = 1'b1;
            end else begin
               r.value = ma % mb;
               if (a[W-1]) r.value = -r.value;
            end
         end
         OPC_POW: r.value = raise_power(a, b);
         default: r.value = '0;
      endcase
      return r;
   endfunction

   // mostly short gaps, a few long ones, with occasional calm stretches of none
   function int unsigned pick_gap(input int side);
      int unsigned r;
      if (calm_left[side] != 0) begin
         calm_left[side]--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm_left[side] = $urandom_range(20, 60);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function word_type pick_operand();
      case ($urandom_range(0, 9))
         0: return extreme_list[$urandom_range(0, 4)];
         1, 2, 3: return $urandom_range(0, 40) - 20;
         default: return $urandom;
      endcase
   endfunction

   task add_op(input logic [OPCODE_WIDTH-1:0] op, input word_type a, input word_type b);
      alu_requests.push_back('{opcode: op, a: a, b: b});
   endtask

   task load_random();
      logic [OPCODE_WIDTH-1:0] op;
      word_type a;
      word_type b;
      int unsigned r;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         r = $urandom_range(0, 99);
         op = (r < 96) ? opcode_list[$urandom_range(0, 5)] : opcode_list[$urandom_range(6, 7)];
         a = pick_operand();
         b = pick_operand();
         if (op == OPC_POW) begin
            r = $urandom_range(0, 9);
            if (r < 5) a = $urandom_range(0, 10) - 5;
            r = $urandom_range(0, 19);
            if (r < 14) b = $urandom_range(0, 40);
            else if (r < 17) b = -$urandom_range(1, 8);
            else b = $urandom;
         end else if ((op == OPC_DIV || op == OPC_REM) && $urandom_range(0, 9) == 0) begin
            b = '0;
         end
         add_op(op, a, b);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_results.push_back(alu_result_of(req_opcode, req_operand_a, req_operand_b));
            op_transfers[req_opcode]++;
            req_gap = pick_gap(0);
         end
         if (!req_valid || !req_stall) begin
            if (req_gap != 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (alu_requests.size() != 0) begin
               next_op = alu_requests.pop_front();
               req_valid <= 1'b1;
               req_opcode <= next_op.opcode;
               req_operand_a <= next_op.a;
               req_operand_b <= next_op.b;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_results.size() == 0) begin
               $error("result transfer with no prediction outstanding");
               mismatch_count++;
            end else begin
               want = predicted_results.pop_front();
               results_checked++;
               if (rsp_divide_by_zero) zero_div_results++;
               if (rsp_result_value !== want.value) begin
                  $error("result_value: expected %0d, actual %0d",
                         $signed(want.value), rsp_result_value);
                  mismatch_count++;
               end
               if (rsp_divide_by_zero !== want.div_zero) begin
                  $error("divide_by_zero: expected %0d, actual %0d",
                         want.div_zero, rsp_divide_by_zero);
                  mismatch_count++;
               end
            end
         end
         if (rsp_hold == 0) rsp_hold = pick_gap(1);
         if (rsp_hold != 0) begin
            rsp_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("** integer_alu_mul_div_mod_pow_core: FAILED **");
      $finish;
   end

   initial begin
      add_op(OPC_ADD, W_MAX, W_ONE);
      add_op(OPC_ADD, W_MIN, W_ALL);
      add_op(OPC_SUB, W_MIN, W_ONE);
      add_op(OPC_SUB, '0, W_MIN);
      add_op(OPC_MUL, W_MAX, W_MAX);
      add_op(OPC_MUL, W_MIN, W_ALL);
      add_op(OPC_DIV, 100, '0);
      add_op(OPC_REM, -5, '0);
      add_op(OPC_DIV, W_MIN, W_ALL);
      add_op(OPC_REM, W_MIN, W_ALL);
      add_op(OPC_DIV, -7, 2);
      add_op(OPC_REM, -7, 2);
      add_op(OPC_REM, 7, -2);
      add_op(OPC_POW, W_ALL, 3);
      add_op(OPC_POW, W_ALL, -4);
      add_op(OPC_POW, W_ALL, -3);
      add_op(OPC_POW, '0, '0);
      add_op(OPC_POW, 7, '0);
      add_op(OPC_POW, W_ONE, -5);
      add_op(OPC_POW, '0, 9);
      add_op(OPC_POW, 2, W_ALL);
      add_op(OPC_POW, 3, 40);
      add_op(OPC_POW, 2, 31);
      add_op(OPC_RSVD_6, 5, 5);
      add_op(OPC_RSVD_7, W_MIN, W_MAX);
      load_random();
      item_total = alu_requests.size();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait (results_checked == item_total);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("transfers in: add %0d sub %0d mul %0d div %0d rem %0d pow %0d unused %0d",
               op_transfers[OPC_ADD], op_transfers[OPC_SUB], op_transfers[OPC_MUL],
               op_transfers[OPC_DIV], op_transfers[OPC_REM], op_transfers[OPC_POW],
               op_transfers[OPC_RSVD_6] + op_transfers[OPC_RSVD_7]);
      $display("results checked %0d, zero divisor %0d, mismatches %0d, cycles %0d",
               results_checked, zero_div_results, mismatch_count, cycle_count);
      if (mismatch_count == 0) begin
         $display("** integer_alu_mul_div_mod_pow_core: PASSED **");
      end else begin
         $display("** integer_alu_mul_div_mod_pow_core: FAILED **");
      end
      $finish;
   end

endmodule
